>>> rtl/san_pkg.sv
// san_pkg: shared types and constants for the stick axis normalizer.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package san_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  // quotient bits below the saturation point (full scale is 2**FRAC_BITS - 1)
  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned NUM_W       = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned OUT_W       = FRAC_BITS + 1;
  localparam int unsigned NUM_CELLS   = FRAC_BITS;

  localparam logic [SAMPLE_BITS-1:0] CENTER_RST = SAMPLE_BITS'(2048);
  localparam logic [SAMPLE_BITS-1:0] UPPER_RST  = SAMPLE_BITS'(4095);
  localparam logic [SAMPLE_BITS-1:0] LOWER_RST  = '0;
  localparam logic [FRAC_BITS-1:0]   FULL_MAG   = '1;

  typedef enum logic [2:0] {
    REG_CENTER = 3'd0,
    REG_UPPER  = 3'd1,
    REG_LOWER  = 3'd2,
    REG_INVERT = 3'd3,
    REG_ENABLE = 3'd4
  } san_reg_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] upper;
    logic [SAMPLE_BITS-1:0] lower;
    logic                   invert;
    logic                   enable;
  } san_cfg_t;

  // one item as it travels along the divider cells
  typedef struct packed {
    logic [NUM_W-1:0]     rem;   // partial remainder
    logic [NUM_W-1:0]     dsh;   // divisor aligned to the current quotient bit
    logic [FRAC_BITS-1:0] quo;
    logic                 neg;   // final result is negative
    logic                 zero;  // result forced to zero
    logic                 sat;   // quotient would exceed full scale
  } san_work_t;

endpackage

`default_nettype wire

>>> rtl/san_front.sv
// san_front: clamp, side selection, span and numerator, first pipeline register.
// Depends on san_pkg.
`default_nettype none

module san_front import san_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire san_cfg_t               cfg_i,
  input  wire logic                   up_valid_i,
  output logic                        up_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] raw_sample_i,
  output logic                        dn_valid_o,
  input  wire logic                   dn_ready_i,
  output san_work_t                   dn_work_o
);

  logic                   valid_q;
  san_work_t              work_q, work_d;
  logic [SAMPLE_BITS-1:0] clip_hi, clip, delta, span;
  logic                   pos, empty;
  logic [NUM_W-1:0]       num, lim;

  assign up_ready_o = !valid_q || dn_ready_i;

  always_comb begin
    // upper clamp first, lower clamp second
    clip_hi = (raw_sample_i > cfg_i.upper) ? cfg_i.upper : raw_sample_i;
    clip    = (clip_hi < cfg_i.lower) ? cfg_i.lower : clip_hi;
    pos     = (clip >= cfg_i.center);
    if (pos) begin
      empty = (cfg_i.upper <= cfg_i.center);
      delta = clip - cfg_i.center;
      span  = cfg_i.upper - cfg_i.center;
      num   = {delta, {FRAC_BITS{1'b0}}} - NUM_W'(delta);
    end else begin
      empty = (cfg_i.center <= cfg_i.lower);
      delta = cfg_i.center - clip;
      span  = cfg_i.center - cfg_i.lower;
      num   = {delta, {FRAC_BITS{1'b0}}};
    end
    lim          = {span, {FRAC_BITS{1'b0}}};
    work_d.rem   = num;
    work_d.dsh   = {1'b0, span, {(FRAC_BITS-1){1'b0}}};
    work_d.quo   = '0;
    work_d.neg   = !pos ^ cfg_i.invert;
    work_d.zero  = empty || !cfg_i.enable;
    work_d.sat   = (num >= lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      work_q <= work_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_work_o  = work_q;

endmodule

`default_nettype wire

>>> rtl/san_div_cell.sv
// san_div_cell: one restoring-division cell, settles one quotient bit per item.
// Depends on san_pkg.
`default_nettype none

module san_div_cell import san_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      up_valid_i,
  output logic           up_ready_o,
  input  wire san_work_t up_work_i,
  output logic           dn_valid_o,
  input  wire logic      dn_ready_i,
  output san_work_t      dn_work_o
);

  logic      valid_q;
  san_work_t work_q, work_d;
  logic      fits;

  assign up_ready_o = !valid_q || dn_ready_i;

  always_comb begin
    work_d     = up_work_i;
    fits       = (up_work_i.rem >= up_work_i.dsh);
    if (fits) begin
      work_d.rem = up_work_i.rem - up_work_i.dsh;
    end
    work_d.quo = {up_work_i.quo[FRAC_BITS-2:0], fits};
    work_d.dsh = {1'b0, up_work_i.dsh[NUM_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      work_q <= work_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_work_o  = work_q;

endmodule

`default_nettype wire

>>> rtl/san_back.sv
// san_back: saturation, sign and output register of the normalizer.
// Depends on san_pkg.
`default_nettype none

module san_back import san_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             up_valid_i,
  output logic                  up_ready_o,
  input  wire san_work_t        up_work_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic signed [OUT_W-1:0] axis_value_o
);

  logic                   valid_q;
  logic [OUT_W-1:0]       value_q, value_d;
  logic [FRAC_BITS-1:0]   mag;

  assign up_ready_o = !valid_q || out_ready_i;

  always_comb begin
    if (up_work_i.zero) begin
      mag = '0;
    end else if (up_work_i.sat) begin
      mag = FULL_MAG;
    end else begin
      mag = up_work_i.quo;
    end
    value_d = up_work_i.neg ? (OUT_W'(0) - {1'b0, mag}) : {1'b0, mag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign axis_value_o = value_q;

endmodule

`default_nettype wire

>>> rtl/stick_axis_normalizer.sv
// Stick axis normalizer: raw converter sample to signed calibrated axis position.
// Top level; uses san_pkg, san_front, san_div_cell and san_back.
//
// Accepts one sample per clock while the output side does not stall and returns
// one result per sample, in order, through one front register (clamp, span,
// numerator), a chain of 15 restoring-division cells that each settle one
// quotient bit, and one output register that applies saturation and sign. Every
// stage holds its own item and takes a new one as soon as its content moves on,
// so empty slots close up during output stalls. Registers are written through
// the configuration channel, which is always ready; writes are meant to happen
// while no sample is in flight.
`default_nettype none

module stick_axis_normalizer import san_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [2:0]             cfg_index_i,
  input  wire logic [SAMPLE_BITS-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] raw_sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [OUT_W-1:0]     axis_value_o
);

  san_cfg_t  cfg_q;
  logic      stage_valid [NUM_CELLS+1];
  logic      stage_ready [NUM_CELLS+1];
  san_work_t stage_work  [NUM_CELLS+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center <= CENTER_RST;
      cfg_q.upper  <= UPPER_RST;
      cfg_q.lower  <= LOWER_RST;
      cfg_q.invert <= 1'b0;
      cfg_q.enable <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (san_reg_e'(cfg_index_i))
        REG_CENTER: cfg_q.center <= cfg_data_i;
        REG_UPPER:  cfg_q.upper  <= cfg_data_i;
        REG_LOWER:  cfg_q.lower  <= cfg_data_i;
        REG_INVERT: cfg_q.invert <= cfg_data_i[0];
        REG_ENABLE: cfg_q.enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  san_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .up_valid_i   (in_valid_i),
    .up_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .dn_valid_o   (stage_valid[0]),
    .dn_ready_i   (stage_ready[0]),
    .dn_work_o    (stage_work[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    san_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (stage_valid[i]),
      .up_ready_o (stage_ready[i]),
      .up_work_i  (stage_work[i]),
      .dn_valid_o (stage_valid[i+1]),
      .dn_ready_i (stage_ready[i+1]),
      .dn_work_o  (stage_work[i+1])
    );
  end

  san_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (stage_valid[NUM_CELLS]),
    .up_ready_o   (stage_ready[NUM_CELLS]),
    .up_work_i    (stage_work[NUM_CELLS]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .axis_value_o (axis_value_o)
  );

endmodule

`default_nettype wire

>>> rtl/san_checker.sv
// san_checker: port-level assertions for the stick axis normalizer, plus bind.
// Depends on san_pkg; attaches to stick_axis_normalizer.
`default_nettype none

module san_checker import san_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   cfg_valid_i,
  input wire logic                   cfg_ready_o,
  input wire logic [2:0]             cfg_index_i,
  input wire logic [SAMPLE_BITS-1:0] cfg_data_i,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic [SAMPLE_BITS-1:0] raw_sample_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic signed [OUT_W-1:0] axis_value_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(axis_value_o))
    else $error("result changed while stalled");

  // saturation keeps the most negative code unused
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> axis_value_o != {1'b1, {(OUT_W-1){1'b0}}})
    else $error("result outside symmetric range");

  // with the output empty the whole chain can move, so input must be ready
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write refused");

endmodule

bind stick_axis_normalizer san_checker u_san_checker (.*);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for stick_axis_normalizer, calibration registers and sample stream
// depends on san_pkg and the rtl of the block; runs standalone

module tb import san_pkg::*;;

  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam longint FULL_POS  = (longint'(1) << FRAC_BITS) - 1;
  localparam longint FULL_NEG  = longint'(1) << FRAC_BITS;
  localparam int RANDOM_ITEMS  = 1480;
  localparam int PHASES        = 12;
  localparam int HOLD_CYCLES   = 64;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct {
    logic [SAMPLE_BITS-1:0]  raw;
    logic signed [OUT_W-1:0] axis;
  } sample_axis_t;

  // tracks calibration registers and the axis values still owed by the block
  class axis_tracker;
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] upper;
    logic [SAMPLE_BITS-1:0] lower;
    logic                   invert;
    logic                   enable;
    sample_axis_t           axis_due[$];
    int                     errors;

    function new();
      center = CENTER_RST;
      upper  = UPPER_RST;
      lower  = LOWER_RST;
      invert = 1'b0;
      enable = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(san_reg_e idx, logic [SAMPLE_BITS-1:0] data);
      case (idx)
        REG_CENTER: center = data;
        REG_UPPER:  upper  = data;
        REG_LOWER:  lower  = data;
        REG_INVERT: invert = data[0];
        REG_ENABLE: enable = data[0];
        default: ;
      endcase
    endfunction

    function logic signed [OUT_W-1:0] calibrated_axis(logic [SAMPLE_BITS-1:0] raw);
      longint r;
      longint c;
      longint hi;
      longint lo;
      longint span;
      longint q;
      r  = raw;
      c  = center;
      hi = upper;
      lo = lower;
      if (!enable) return '0;
      // upper clamp first, so a lower limit above the upper one wins
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      if (r >= c) begin
        span = hi - c;
        if (span < 1) return '0;
        q = ((r - c) * FULL_POS) / span;
      end else begin
        span = c - lo;
        if (span < 1) return '0;
        q = -(((c - r) * FULL_NEG) / span);
      end
      if (q > FULL_POS) q = FULL_POS;
      if (q < -FULL_POS) q = -FULL_POS;
      if (invert) q = -q;
      return OUT_W'(q);
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] raw);
      sample_axis_t e;
      e.raw  = raw;
      e.axis = calibrated_axis(raw);
      axis_due.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch @%0t: %s", $time, msg);
    endtask

    task check_axis(logic signed [OUT_W-1:0] got);
      sample_axis_t e;
      if (axis_due.size() == 0) begin
        report($sformatf("axis_value %0d with no sample pending", got));
        return;
      end
      e = axis_due.pop_front();
      if (got !== e.axis)
        report($sformatf("raw %0d: axis_value got %0d expected %0d", e.raw, got, e.axis));
    endtask
  endclass

  logic                   clk_i        = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i  = 1'b0;
  logic                   cfg_ready_o;
  logic [2:0]             cfg_index_i  = REG_CENTER;
  logic [SAMPLE_BITS-1:0] cfg_data_i   = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] raw_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic signed [OUT_W-1:0] axis_value_o;

  axis_tracker sb;
  rx_mode_e    rx_mode    = RX_ALWAYS;
  int          hold_epoch = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  int          rx_tick    = 0;
  int          rx_period  = 4;
  int          rx_low     = 1;
  int          cycle_count = 0;

  stick_axis_normalizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .axis_value_o (axis_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[stick_axis_normalizer] ERROR");
      $finish;
    end
  end

  // output side: stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_epoch) begin
      hold_seen = hold_epoch;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_RANDOM: out_ready_i <= ($urandom_range(0, 99) < 70);
        default: begin
          out_ready_i <= (rx_tick >= rx_low);
          rx_tick = rx_tick + 1;
          if (rx_tick >= rx_period) begin
            rx_tick   = 0;
            rx_period = $urandom_range(2, 8);
            rx_low    = $urandom_range(0, rx_period - 1);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_axis(axis_value_o);
  end

  task automatic cfg_write(san_reg_e idx, logic [SAMPLE_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_cal(logic [SAMPLE_BITS-1:0] c, logic [SAMPLE_BITS-1:0] hi,
                         logic [SAMPLE_BITS-1:0] lo, logic inv, logic en);
    cfg_write(REG_CENTER, c);
    cfg_write(REG_UPPER, hi);
    cfg_write(REG_LOWER, lo);
    cfg_write(REG_INVERT, SAMPLE_BITS'(inv));
    cfg_write(REG_ENABLE, SAMPLE_BITS'(en));
  endtask

  task automatic send_sample(logic [SAMPLE_BITS-1:0] raw);
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(raw);
  endtask

  // stop offering samples and wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.axis_due.size() != 0);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 6))
      0, 1:    s = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      2:       s = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
      3:       s = SAMPLE_BITS'(sb.center + $urandom_range(0, 6) - 3);
      4:       s = SAMPLE_BITS'(sb.upper + $urandom_range(0, 4) - 2);
      5:       s = SAMPLE_BITS'(sb.lower + $urandom_range(0, 4) - 2);
      default: s = SAMPLE_BITS'($urandom_range(sb.lower, sb.upper));
    endcase
    return s;
  endfunction

  task automatic random_config();
    logic [SAMPLE_BITS-1:0] c;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] inv_word;
    logic [SAMPLE_BITS-1:0] en_word;
    case ($urandom_range(0, 4))
      0: begin
        c  = SAMPLE_BITS'($urandom_range(1000, 3000));
        lo = SAMPLE_BITS'($urandom_range(0, c - 1));
        hi = SAMPLE_BITS'($urandom_range(c + 1, SAMPLE_MAX));
      end
      1: begin
        c  = ($urandom_range(0, 2) == 0) ? '0 :
             ($urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : CENTER_RST);
        hi = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
        lo = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
      end
      2: begin
        c  = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        hi = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        lo = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      end
      3: begin
        // very narrow spans around the rest point
        c  = SAMPLE_BITS'($urandom_range(2, SAMPLE_MAX - 2));
        hi = SAMPLE_BITS'(c + $urandom_range(0, 2));
        lo = SAMPLE_BITS'(c - $urandom_range(0, 2));
      end
      default: begin
        c  = CENTER_RST;
        hi = UPPER_RST;
        lo = LOWER_RST;
      end
    endcase
    // the one-bit registers get random upper bits too
    inv_word = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    en_word  = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    en_word[0] = ($urandom_range(0, 9) != 0);
    cfg_write(REG_CENTER, c);
    cfg_write(REG_UPPER, hi);
    cfg_write(REG_LOWER, lo);
    cfg_write(REG_INVERT, inv_word);
    cfg_write(REG_ENABLE, en_word);
  endtask

  task automatic send_phase(int count, int gap_max);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_sample(pick_sample());
      left = left - burst;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic directed_items();
    // reset values: calibration off
    send_sample('0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    drain();
    cfg_write(REG_ENABLE, SAMPLE_BITS'(1));
    send_sample('0);
    send_sample(SAMPLE_BITS'(1));
    send_sample(SAMPLE_BITS'(2047));
    send_sample(SAMPLE_BITS'(2048));
    send_sample(SAMPLE_BITS'(2049));
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    drain();
    cfg_write(REG_INVERT, SAMPLE_BITS'(1));
    send_sample('0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(SAMPLE_BITS'(2048));
    drain();
    // upper limit equal to center: no positive span
    set_cal(12'd1000, 12'd1000, 12'd0, 1'b0, 1'b1);
    send_sample(SAMPLE_BITS'(1000));
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(SAMPLE_BITS'(500));
    drain();
    // lower limit above upper and above center: negative span, inverted
    set_cal(12'd1000, 12'd500, 12'd2000, 1'b1, 1'b1);
    send_sample('0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    drain();
    // clamped sample far past the span: saturation before inversion
    set_cal(12'd100, 12'd200, 12'd3000, 1'b1, 1'b1);
    send_sample('0);
    drain();
    // full negative deflection gives 32768 before saturation
    set_cal(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX), 12'd0, 1'b0, 1'b1);
    send_sample('0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    drain();
    cfg_write(REG_INVERT, SAMPLE_BITS'(1));
    send_sample('0);
  endtask

  initial begin
    sb = new();
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      random_config();
      if (p == 3 || p == 8) begin
        // long output hold-off while samples keep coming
        rx_mode    <= RX_ALWAYS;
        hold_epoch <= hold_epoch + 1;
        send_phase(RANDOM_ITEMS / PHASES, 0);
      end else begin
        rx_mode <= rx_mode_e'($urandom_range(0, 2));
        send_phase(RANDOM_ITEMS / PHASES, (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 10));
      end
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.axis_due.size() != 0)
      sb.report($sformatf("%0d axis values never returned", sb.axis_due.size()));
    if (sb.errors == 0) begin
      $display("[stick_axis_normalizer] OK");
    end else begin
      $display("[stick_axis_normalizer] ERROR");
    end
    $finish;
  end

endmodule
